// ===== rtl/core/cst_pkg.sv =====
// Shared types, constants and character/keyword helpers for the C-subset token scanner.
package cst_pkg;

	// Default configuration
	localparam int KEYWORD_PREFIX_CHARS_DEF = 6;
	localparam int LENGTH_LIMIT_DEF         = 255;
	localparam int QUEUE_DEPTH_DEF          = 4;

	// Token kinds
	localparam logic [5:0] KIND_END      = 6'd0;
	localparam logic [5:0] KIND_IDENT    = 6'd1;
	localparam logic [5:0] KIND_NUMBER   = 6'd2;
	localparam logic [5:0] KIND_KEYWORD0 = 6'd3;
	localparam logic [5:0] KIND_SINGLE0  = 6'd17;
	localparam logic [5:0] KIND_ILLEGAL  = 6'd38;

	// Operator kinds that follow the single-character operators
	localparam logic [5:0] KIND_LOR    = 6'd28;
	localparam logic [5:0] KIND_LAND   = 6'd29;
	localparam logic [5:0] KIND_EQ     = 6'd30;
	localparam logic [5:0] KIND_ASSIGN = 6'd31;
	localparam logic [5:0] KIND_NE     = 6'd32;
	localparam logic [5:0] KIND_NOT    = 6'd33;
	localparam logic [5:0] KIND_LE     = 6'd34;
	localparam logic [5:0] KIND_LT     = 6'd35;
	localparam logic [5:0] KIND_GE     = 6'd36;
	localparam logic [5:0] KIND_GT     = 6'd37;

	// Number of keywords and two-character operator leaders
	localparam int NUM_KEYWORDS = 14;
	localparam int NUM_PEND     = 6;
	localparam int NUM_SINGLE   = 11;

	// Character classes
	typedef enum logic [2:0] {
		CLS_ALPHA  = 3'd0,
		CLS_DIGIT  = 3'd1,
		CLS_SPACE  = 3'd2,
		CLS_PEND   = 3'd3,
		CLS_SINGLE = 3'd4,
		CLS_OTHER  = 3'd5
	} cls_t;

	// One classified input item
	typedef struct packed {
		logic       eoi;
		cls_t       cls;
		logic [3:0] idx;
		logic [7:0] ch;
	} item_t;

	// Pending operator index of the character that completes the pair
	localparam logic [2:0] PEND_BAR = 3'd0;
	localparam logic [2:0] PEND_AMP = 3'd1;
	localparam logic [2:0] PEND_EQ  = 3'd2;

	// Kinds for a pending operator: as a pair and on its own
	localparam logic [5:0] PEND_PAIR_KIND [NUM_PEND] = '{
		KIND_LOR, KIND_LAND, KIND_EQ, KIND_NE, KIND_LE, KIND_GE
	};
	localparam logic [5:0] PEND_ALONE_KIND [NUM_PEND] = '{
		KIND_ILLEGAL, KIND_ILLEGAL, KIND_ASSIGN, KIND_NOT, KIND_LT, KIND_GT
	};

	// Keyword text, first character in the low byte (strings are written reversed)
	localparam logic [47:0] KW_TEXT [NUM_KEYWORDS] = '{
		{16'h0, "loob"}, {32'h0, "od"}, {16'h0, "esle"}, {8'h0, "eslaf"},
		{8'h0, "taolf"}, {24'h0, "rof"}, {32'h0, "fi"}, {24'h0, "tni"},
		"ftnirp", "nruter", {8'h0, "fnacs"}, {16'h0, "eurt"},
		{16'h0, "diov"}, {8'h0, "elihw"}
	};
	localparam logic [2:0] KW_LEN [NUM_KEYWORDS] = '{
		3'd4, 3'd2, 3'd4, 3'd5, 3'd5, 3'd3, 3'd2, 3'd3,
		3'd6, 3'd6, 3'd5, 3'd4, 3'd4, 3'd5
	};

	// Classify one source byte
	function automatic item_t classify(input logic [7:0] ch, input logic eoi);
		item_t it;
		it.eoi = eoi;
		it.ch  = ch;
		it.idx = 4'd0;
		it.cls = CLS_OTHER;
		if ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z")) begin
			it.cls = CLS_ALPHA;
		end else if (ch >= "0" && ch <= "9") begin
			it.cls = CLS_DIGIT;
		end else begin
			unique case (ch)
				" ", 8'h09, 8'h0a, 8'h0d: it.cls = CLS_SPACE;
				"|": begin it.cls = CLS_PEND; it.idx = 4'd0; end
				"&": begin it.cls = CLS_PEND; it.idx = 4'd1; end
				"=": begin it.cls = CLS_PEND; it.idx = 4'd2; end
				"!": begin it.cls = CLS_PEND; it.idx = 4'd3; end
				"<": begin it.cls = CLS_PEND; it.idx = 4'd4; end
				">": begin it.cls = CLS_PEND; it.idx = 4'd5; end
				"+": begin it.cls = CLS_SINGLE; it.idx = 4'd0; end
				"-": begin it.cls = CLS_SINGLE; it.idx = 4'd1; end
				"*": begin it.cls = CLS_SINGLE; it.idx = 4'd2; end
				"/": begin it.cls = CLS_SINGLE; it.idx = 4'd3; end
				"%": begin it.cls = CLS_SINGLE; it.idx = 4'd4; end
				"(": begin it.cls = CLS_SINGLE; it.idx = 4'd5; end
				")": begin it.cls = CLS_SINGLE; it.idx = 4'd6; end
				"{": begin it.cls = CLS_SINGLE; it.idx = 4'd7; end
				"}": begin it.cls = CLS_SINGLE; it.idx = 4'd8; end
				",": begin it.cls = CLS_SINGLE; it.idx = 4'd9; end
				";": begin it.cls = CLS_SINGLE; it.idx = 4'd10; end
				default: it.cls = CLS_OTHER;
			endcase
		end
		return it;
	endfunction

	// Word kind from the first six characters and the exact length
	function automatic logic [5:0] keyword_kind(input logic [47:0] pfx, input logic [15:0] len);
		logic [5:0] kind;
		kind = KIND_IDENT;
		for (int k = 0; k < NUM_KEYWORDS; k++) begin
			if (len == 16'(KW_LEN[k]) && pfx == KW_TEXT[k]) begin
				kind = KIND_KEYWORD0 + 6'(k);
			end
		end
		return kind;
	endfunction

endpackage

// ===== rtl/core/c_subset_token_scanner.sv =====
// Top level of the C-subset token scanner: front, item queue, scanner, token queue.
//
//   channel   direction  handshake     payload
//   source    in         push / full   character, end_of_input
//   tokens    out        pop / empty   token_kind, token_start, token_length, last_of_run
//
// One source byte is taken per cycle while full is low. An item that causes two
// tokens holds the scanner until both are written, since the scanner writes one
// token per cycle into the token queue while it has room. A token passes through the
// front stage, the item queue, the scanner and the token queue to the outputs. Reset
// clears the scan state, position and both queues at once; no clearing pass follows.
// A stalled consumer fills the token queue, then the item queue, then raises full.
module c_subset_token_scanner #(
	parameter int KEYWORD_PREFIX_CHARS = cst_pkg::KEYWORD_PREFIX_CHARS_DEF,
	parameter int LENGTH_LIMIT         = cst_pkg::LENGTH_LIMIT_DEF,
	parameter int QUEUE_DEPTH          = cst_pkg::QUEUE_DEPTH_DEF,
	parameter int CNT_W                = $clog2(LENGTH_LIMIT + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [7:0]       character,
	input  logic             end_of_input,
	output logic             empty,
	input  logic             pop,
	output logic [5:0]       token_kind,
	output logic [31:0]      token_start,
	output logic [CNT_W-1:0] token_length,
	output logic             last_of_run
);
	import cst_pkg::*;

	localparam int TOK_W = 6 + 32 + CNT_W + 1;

	item_t            front_item, head_item;
	logic             front_valid, item_full, item_empty, item_pop;
	logic             tok_push, tok_full, tok_last;
	logic [5:0]       tok_kind;
	logic [31:0]      tok_start;
	logic [CNT_W-1:0] tok_length;
	logic [TOK_W-1:0] tok_word, out_word;
	logic [$bits(item_t)-1:0] head_bits;

	// Accept and classify
	cst_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.character    (character),
		.end_of_input (end_of_input),
		.item_valid   (front_valid),
		.item         (front_item),
		.item_full    (item_full)
	);

	// Classified items between front and scanner
	cst_queue #(.WIDTH($bits(item_t)), .DEPTH(QUEUE_DEPTH)) u_item_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_valid),
		.wr_data (front_item),
		.full    (item_full),
		.rd_en   (item_pop),
		.rd_data (head_bits),
		.empty   (item_empty)
	);

	assign head_item = item_t'(head_bits);

	// Scan into tokens
	cst_back #(
		.KEYWORD_PREFIX_CHARS (KEYWORD_PREFIX_CHARS),
		.LENGTH_LIMIT         (LENGTH_LIMIT),
		.CNT_W                (CNT_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (!item_empty),
		.in_item    (head_item),
		.in_pop     (item_pop),
		.tok_push   (tok_push),
		.tok_full   (tok_full),
		.tok_kind   (tok_kind),
		.tok_start  (tok_start),
		.tok_length (tok_length),
		.tok_last   (tok_last)
	);

	// Token queue toward the consumer
	assign tok_word = {tok_kind, tok_start, tok_length, tok_last};

	cst_queue #(.WIDTH(TOK_W), .DEPTH(QUEUE_DEPTH)) u_tok_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (tok_push),
		.wr_data (tok_word),
		.full    (tok_full),
		.rd_en   (pop),
		.rd_data (out_word),
		.empty   (empty)
	);

	assign {token_kind, token_start, token_length, last_of_run} = out_word;
endmodule

// ===== rtl/core/cst_queue.sv =====
// Small synchronous queue with registered occupancy flags.
module cst_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Occupancy never exceeds the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue occupancy above depth");

	// A write while full is dropped, so occupancy holds
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		full && !rd_en |=> full)
		else $error("queue lost full state without a read");

	// A read while not empty frees one entry
	a_read_frees: assert property (@(posedge clk) disable iff (!arst_n)
		do_rd && !do_wr |=> !full)
		else $error("queue still full after a read");
endmodule

// ===== rtl/core/cst_front.sv =====
// Front end: accepts source bytes, classifies them and feeds the item queue.
module cst_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [7:0]    character,
	input  logic          end_of_input,
	output logic          item_valid,
	output cst_pkg::item_t item,
	input  logic          item_full
);
	import cst_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	logic  take;

	// Stage one holds its item until the queue has room
	assign full       = valid_s1 && item_full;
	assign take       = push && !full;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (!item_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= classify(character, end_of_input);
		end
	end

	// A held item stays put while the queue is full
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && item_full |=> valid_s1 && $stable(item_s1))
		else $error("front item changed while stalled");

	// Stage one is refilled only through an input transfer
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 && !push |=> !valid_s1)
		else $error("front stage filled without a transfer");

	// Stage one drains when the queue takes it and nothing new arrives
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !item_full && !push |=> !valid_s1)
		else $error("front stage did not drain");
endmodule

// ===== rtl/core/cst_back.sv =====
// Back end: scan state machine that turns classified items into tokens.
module cst_back #(
	parameter int KEYWORD_PREFIX_CHARS = cst_pkg::KEYWORD_PREFIX_CHARS_DEF,
	parameter int LENGTH_LIMIT         = cst_pkg::LENGTH_LIMIT_DEF,
	parameter int CNT_W                = $clog2(LENGTH_LIMIT + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  cst_pkg::item_t   in_item,
	output logic             in_pop,
	output logic             tok_push,
	input  logic             tok_full,
	output logic [5:0]       tok_kind,
	output logic [31:0]      tok_start,
	output logic [CNT_W-1:0] tok_length,
	output logic             tok_last
);
	import cst_pkg::*;

	localparam int PFX_W = 8 * KEYWORD_PREFIX_CHARS;
	localparam logic [CNT_W-1:0] LIMIT = CNT_W'(LENGTH_LIMIT);

	typedef enum logic [3:0] {
		MODE_IDLE   = 4'b0001,
		MODE_WORD   = 4'b0010,
		MODE_NUMBER = 4'b0100,
		MODE_PEND   = 4'b1000
	} mode_t;

	// One token candidate
	typedef struct packed {
		logic             valid;
		logic [5:0]       kind;
		logic [31:0]      start;
		logic [CNT_W-1:0] len;
	} tok_t;

	mode_t            mode_q, mode_d;
	logic [2:0]       pend_q, pend_d;
	logic [PFX_W-1:0] prefix_q, prefix_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [31:0]      lex_start_q, lex_start_d;
	logic [31:0]      pos_q;
	logic             phase_q;

	tok_t       flush_tok, tok_a, tok_b, tok_out;
	logic       two, any, advance;
	logic [2:0] pair_idx;
	logic       extend, start_lex;
	logic [7:0] ch;

	assign ch       = in_item.ch;
	assign pair_idx = (pend_q == PEND_BAR || pend_q == PEND_AMP) ? pend_q : PEND_EQ;

	// Token for whatever lexeme is pending
	always_comb begin
		flush_tok.valid = (mode_q != MODE_IDLE);
		flush_tok.start = lex_start_q;
		flush_tok.len   = count_q;
		flush_tok.kind  = KIND_NUMBER;
		unique case (mode_q)
			MODE_WORD:   flush_tok.kind = keyword_kind(prefix_q[47:0], 16'(count_q));
			MODE_NUMBER: flush_tok.kind = KIND_NUMBER;
			MODE_PEND: begin
				flush_tok.kind = PEND_ALONE_KIND[pend_q];
				flush_tok.len  = CNT_W'(1);
			end
			default: flush_tok.kind = KIND_NUMBER;
		endcase
	end

	// Tokens caused by the head item and the next scan state
	always_comb begin
		tok_a       = '0;
		tok_b       = '0;
		mode_d      = mode_q;
		pend_d      = pend_q;
		prefix_d    = prefix_q;
		count_d     = count_q;
		lex_start_d = lex_start_q;
		extend      = 1'b0;
		start_lex   = 1'b0;
		if (in_item.eoi) begin
			tok_a  = flush_tok;
			tok_b  = '{valid: 1'b1, kind: KIND_END, start: pos_q, len: '0};
			mode_d = MODE_IDLE;
		end else if ((mode_q == MODE_WORD &&
				(in_item.cls == CLS_ALPHA || in_item.cls == CLS_DIGIT)) ||
				(mode_q == MODE_NUMBER && in_item.cls == CLS_DIGIT)) begin
			extend = 1'b1;
		end else if (mode_q == MODE_PEND && in_item.cls == CLS_PEND &&
				in_item.idx[2:0] == pair_idx) begin
			tok_b  = '{valid: 1'b1, kind: PEND_PAIR_KIND[pend_q], start: lex_start_q,
				len: CNT_W'(2)};
			mode_d = MODE_IDLE;
		end else begin
			tok_a  = flush_tok;
			mode_d = MODE_IDLE;
			case (in_item.cls)
				CLS_SPACE: ;
				CLS_ALPHA: begin
					mode_d    = MODE_WORD;
					start_lex = 1'b1;
				end
				CLS_DIGIT: begin
					mode_d    = MODE_NUMBER;
					start_lex = 1'b1;
				end
				CLS_PEND: begin
					mode_d    = MODE_PEND;
					pend_d    = in_item.idx[2:0];
					start_lex = 1'b1;
				end
				CLS_SINGLE: tok_b = '{valid: 1'b1, kind: KIND_SINGLE0 + 6'(in_item.idx),
					start: pos_q, len: CNT_W'(1)};
				default: tok_b = '{valid: 1'b1, kind: KIND_ILLEGAL, start: pos_q,
					len: CNT_W'(1)};
			endcase
		end
		// Lexeme text bookkeeping
		if (start_lex) begin
			prefix_d    = PFX_W'(ch);
			count_d     = CNT_W'(1);
			lex_start_d = pos_q;
		end else if (extend) begin
			for (int b = 0; b < KEYWORD_PREFIX_CHARS; b++) begin
				if (count_q == CNT_W'(b)) begin
					prefix_d[8*b +: 8] = ch;
				end
			end
			if (count_q < LIMIT) begin
				count_d = count_q + 1'b1;
			end
		end
	end

	// Output one token per cycle while the queue has room; a two-token item sends tok_a, then tok_b
	assign two      = tok_a.valid && tok_b.valid;
	assign any      = tok_a.valid || tok_b.valid;
	assign tok_out  = (phase_q || !tok_a.valid) ? tok_b : tok_a;
	assign tok_push = in_valid && any && !tok_full;
	assign advance  = in_valid && (!any || !tok_full) && (phase_q || !two);
	assign in_pop   = advance;

	assign tok_kind   = tok_out.kind;
	assign tok_start  = tok_out.start;
	assign tok_length = tok_out.len;
	assign tok_last   = phase_q || !two;

	// Scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			pend_q      <= '0;
			prefix_q    <= '0;
			count_q     <= '0;
			lex_start_q <= '0;
			pos_q       <= '0;
			phase_q     <= 1'b0;
		end else begin
			if (advance) begin
				mode_q      <= mode_d;
				pend_q      <= pend_d;
				prefix_q    <= prefix_d;
				count_q     <= count_d;
				lex_start_q <= lex_start_d;
				if (!in_item.eoi) begin
					pos_q <= pos_q + 32'd1;
				end
				phase_q <= 1'b0;
			end else if (in_valid && !tok_full && two && !phase_q) begin
				phase_q <= 1'b1;
			end
		end
	end

	// A token is only written into a queue with room
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		tok_push |-> !tok_full)
		else $error("token written into full queue");

	// The second half of a two-token item still has its item at the head
	a_phase_item: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> in_valid)
		else $error("second token without its item");

	// Pending operator index stays in range
	a_pend_range: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_PEND |-> pend_q < 3'(NUM_PEND))
		else $error("pending operator index out of range");

	// Lexeme length never passes its limit
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LIMIT)
		else $error("lexeme length above limit");
endmodule
